// File: src/uart_rm_pkg.sv
package uart_rm_pkg;

  typedef struct packed {
    logic [1:0] operation;
    logic [2:0] reg_index;
    logic [7:0] write_data;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_dropped;
    logic [2:0] interrupt_id;
  } out_t;

  // classified item passed from the front to the back
  typedef struct packed {
    logic [1:0] op;
    logic [2:0] idx;
    logic [7:0] data;
    logic       ro;
  } cmd_t;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_RX    = 2'd2;
  localparam logic [1:0] OP_TX    = 2'd3;

  localparam logic [2:0] REG_DATA = 3'd0;
  localparam logic [2:0] REG_IER  = 3'd1;
  localparam logic [2:0] REG_IIR  = 3'd2;
  localparam logic [2:0] REG_LCR  = 3'd3;
  localparam logic [2:0] REG_LSR  = 3'd5;
  localparam logic [2:0] REG_MSR  = 3'd6;

  localparam logic [7:0] LCR_DLAB   = 8'h80;
  localparam logic [7:0] LSR_DR     = 8'h01;
  localparam logic [7:0] LSR_OE     = 8'h02;
  localparam logic [7:0] LSR_RD_CLR = 8'h0E;
  localparam logic [7:0] LSR_ERR    = 8'h1E;
  localparam logic [7:0] LSR_THRE   = 8'h20;
  localparam logic [7:0] LSR_TX_EMP = 8'h60;
  localparam logic [7:0] MSR_THRE   = 8'h10;

  localparam logic [2:0] IIR_LINE = 3'd6;
  localparam logic [2:0] IIR_RDA  = 3'd4;
  localparam logic [2:0] IIR_THRE = 3'd2;
  localparam logic [2:0] IIR_NONE = 3'd1;

endpackage

// File: src/uart_rm_front.sv
module uart_rm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  uart_rm_pkg::in_t    in_data,
  output logic                push_valid,
  input  logic                push_ready,
  output uart_rm_pkg::cmd_t   push_cmd
);

  logic              hold_valid_r;
  uart_rm_pkg::cmd_t hold_r;
  uart_rm_pkg::cmd_t cls;

  always_comb begin
    cls.op   = in_data.operation;
    cls.idx  = in_data.reg_index;
    cls.data = (in_data.operation == uart_rm_pkg::OP_RX) ? in_data.rx_byte
                                                         : in_data.write_data;
    // writes to iir, lsr and msr have no effect
    cls.ro   = (in_data.operation == uart_rm_pkg::OP_WRITE) &&
               (in_data.reg_index inside {uart_rm_pkg::REG_IIR, uart_rm_pkg::REG_LSR,
                                          uart_rm_pkg::REG_MSR});
  end

  assign in_ready   = !hold_valid_r || push_ready;
  assign push_valid = hold_valid_r;
  assign push_cmd   = hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_ready) begin
      hold_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_r <= cls;
    end
  end

endmodule

// File: src/uart_rm_queue.sv
module uart_rm_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  uart_rm_pkg::cmd_t   push_cmd,
  output logic                q_valid,
  input  logic                q_ready,
  output uart_rm_pkg::cmd_t   q_cmd
);

  uart_rm_pkg::cmd_t ent_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        count_r;
  logic              push;
  logic              pop;

  assign push_ready = (count_r != 2'd2);
  assign q_valid    = (count_r != 2'd0);
  assign q_cmd      = ent_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: src/uart_rm_back.sv
module uart_rm_back #(
  parameter int FIFO_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_ready,
  input  uart_rm_pkg::cmd_t   q_cmd,
  output logic                out_valid,
  input  logic                out_ready,
  output uart_rm_pkg::out_t   out_data
);

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam logic [PW-1:0] LAST = PW'(FIFO_DEPTH - 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    return (p == LAST) ? '0 : p + PW'(1);
  endfunction

  logic              st_r, st_nxt;
  uart_rm_pkg::cmd_t cmd_r;
  logic [7:0]        rf_r [8];
  logic [7:0]        rf_nxt [8];
  logic [7:0]        div_r [2];
  logic [7:0]        div_nxt [2];
  logic [PW-1:0]     tx_head_r, tx_head_nxt, tx_tail_r, tx_tail_nxt;
  logic [PW-1:0]     rx_head_r, rx_head_nxt, rx_tail_r, rx_tail_nxt;
  logic [7:0]        tx_mem [FIFO_DEPTH];
  logic [7:0]        rx_mem [FIFO_DEPTH];
  logic [7:0]        tx_rd_r, rx_rd_r;
  logic              tx_we, rx_we;
  logic              out_valid_r;
  uart_rm_pkg::out_t out_r, res;
  logic              pop;

  // take an item only when the result register is free by the time it executes
  assign q_ready   = (st_r == S_IDLE) && (!out_valid_r || out_ready);
  assign pop       = q_valid && q_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    logic          latch;
    logic [PW-1:0] tx_hn, tx_hnn, tx_tn, rx_hn, rx_tn;
    logic [7:0]    lsr;
    logic [7:0]    msr;
    logic [2:0]    iir;
    rf_nxt      = rf_r;
    div_nxt     = div_r;
    tx_head_nxt = tx_head_r;
    tx_tail_nxt = tx_tail_r;
    rx_head_nxt = rx_head_r;
    rx_tail_nxt = rx_tail_r;
    tx_we       = 1'b0;
    rx_we       = 1'b0;
    res         = '0;
    st_nxt      = st_r;
    latch       = (rf_r[uart_rm_pkg::REG_LCR] & uart_rm_pkg::LCR_DLAB) != 8'h00;
    tx_hn       = ring_next(tx_head_r);
    tx_hnn      = ring_next(tx_hn);
    tx_tn       = ring_next(tx_tail_r);
    rx_hn       = ring_next(rx_head_r);
    rx_tn       = ring_next(rx_tail_r);
    lsr         = rf_r[uart_rm_pkg::REG_LSR];
    msr         = 8'h00;
    iir         = uart_rm_pkg::IIR_NONE;

    if (st_r == S_IDLE) begin
      if (pop) st_nxt = S_EXEC;
    end else begin
      st_nxt = S_IDLE;
      case (cmd_r.op)
        uart_rm_pkg::OP_WRITE: begin
          if (cmd_r.ro) begin
            lsr = lsr;
          end else if (cmd_r.idx[2:1] == 2'b00 && latch) begin
            div_nxt[cmd_r.idx[0]] = cmd_r.data;
          end else if (cmd_r.idx != uart_rm_pkg::REG_DATA) begin
            rf_nxt[cmd_r.idx] = cmd_r.data;
          end else begin
            lsr = lsr & ~uart_rm_pkg::LSR_TX_EMP;
            if (tx_hn == tx_tail_r) begin
              lsr = lsr | uart_rm_pkg::LSR_OE;
            end else begin
              tx_we       = 1'b1;
              tx_head_nxt = tx_hn;
              if (tx_hnn != tx_tail_r) lsr = lsr | uart_rm_pkg::LSR_TX_EMP;
            end
          end
        end
        uart_rm_pkg::OP_READ: begin
          res.read_data = rf_r[cmd_r.idx];
          if (cmd_r.idx[2:1] == 2'b00) begin
            if (latch) begin
              res.read_data = div_r[cmd_r.idx[0]];
            end else if (cmd_r.idx == uart_rm_pkg::REG_DATA) begin
              lsr = lsr & ~uart_rm_pkg::LSR_DR;
              if (rx_head_r != rx_tail_r) begin
                rf_nxt[uart_rm_pkg::REG_DATA] = rx_rd_r;
                res.read_data = rx_rd_r;
                rx_tail_nxt   = rx_tn;
                if (rx_head_r != rx_tn) lsr = lsr | uart_rm_pkg::LSR_DR;
              end
            end
          end else if (cmd_r.idx == uart_rm_pkg::REG_LSR) begin
            lsr = lsr & ~uart_rm_pkg::LSR_RD_CLR;
          end
        end
        uart_rm_pkg::OP_RX: begin
          if (rx_hn == rx_tail_r) begin
            res.rx_dropped = 1'b1;
            if (rx_head_r != rx_tail_r) lsr = lsr | uart_rm_pkg::LSR_DR;
          end else begin
            rx_we       = 1'b1;
            rx_head_nxt = rx_hn;
            if (rx_hn != rx_tail_r) lsr = lsr | uart_rm_pkg::LSR_DR;
          end
        end
        uart_rm_pkg::OP_TX: begin
          if (tx_head_r != tx_tail_r) begin
            res.tx_valid = 1'b1;
            res.tx_byte  = tx_rd_r;
            tx_tail_nxt  = tx_tn;
          end
          if (tx_hn != tx_tail_nxt) lsr = lsr | uart_rm_pkg::LSR_TX_EMP;
          if (rx_head_r != rx_tail_r) lsr = lsr | uart_rm_pkg::LSR_DR;
        end
        default: begin
          lsr = lsr;
        end
      endcase

      // interrupt identification follows the updated line status
      msr = rf_nxt[uart_rm_pkg::REG_MSR] & ~uart_rm_pkg::MSR_THRE;
      if ((lsr & uart_rm_pkg::LSR_THRE) != 8'h00) msr = msr | uart_rm_pkg::MSR_THRE;
      if ((lsr & uart_rm_pkg::LSR_ERR) != 8'h00) begin
        iir = uart_rm_pkg::IIR_LINE;
      end else if ((lsr & uart_rm_pkg::LSR_DR) != 8'h00) begin
        iir = uart_rm_pkg::IIR_RDA;
      end else if ((lsr & uart_rm_pkg::LSR_THRE) != 8'h00) begin
        iir = uart_rm_pkg::IIR_THRE;
      end else begin
        iir = uart_rm_pkg::IIR_NONE;
      end
      rf_nxt[uart_rm_pkg::REG_LSR] = lsr;
      rf_nxt[uart_rm_pkg::REG_MSR] = msr;
      rf_nxt[uart_rm_pkg::REG_IIR] = {5'b00000, iir};
      res.interrupt_id = iir;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
      tx_head_r   <= '0;
      tx_tail_r   <= '0;
      rx_head_r   <= '0;
      rx_tail_r   <= '0;
      rf_r        <= '{default: 8'h00};
      div_r       <= '{default: 8'h00};
    end else begin
      st_r      <= st_nxt;
      tx_head_r <= tx_head_nxt;
      tx_tail_r <= tx_tail_nxt;
      rx_head_r <= rx_head_nxt;
      rx_tail_r <= rx_tail_nxt;
      rf_r      <= rf_nxt;
      div_r     <= div_nxt;
      if (st_r == S_EXEC) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cmd_r <= q_cmd;
    if (st_r == S_EXEC) out_r <= res;
  end

  // fifo memories: read the tail as the item is taken, write the head on execute
  always_ff @(posedge clk) begin
    if (tx_we) tx_mem[tx_head_r] <= cmd_r.data;
    if (pop) tx_rd_r <= tx_mem[tx_tail_r];
  end

  always_ff @(posedge clk) begin
    if (rx_we) rx_mem[rx_head_r] <= cmd_r.data;
    if (pop) rx_rd_r <= rx_mem[rx_tail_r];
  end

endmodule

// File: src/uart_register_model_with_fifos.sv
// channel | direction | handshake           | payload
// in_     | input     | in_valid / in_ready   | uart_rm_pkg::in_t
// out_    | output    | out_valid / out_ready | uart_rm_pkg::out_t
//
// the back end reads both fifo memories at their tails as it takes an item,
// then updates registers, pointers and the result register, taking no other
// item meanwhile. out_valid is set after front register, queue and execute state.
// rst_n is synchronous; the fifo memories are not cleared.
// while a result waits, the queue and the front register take up to three more
// items before in_ready drops.
module uart_register_model_with_fifos #(
  parameter int FIFO_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  uart_rm_pkg::in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output uart_rm_pkg::out_t out_data
);

  logic              push_valid;
  logic              push_ready;
  uart_rm_pkg::cmd_t push_cmd;
  logic              q_valid;
  logic              q_ready;
  uart_rm_pkg::cmd_t q_cmd;

  uart_rm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  uart_rm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_cmd      (q_cmd)
  );

  uart_rm_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_cmd     (q_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
